FILE: design/jsu_pkg.sv
package jsu_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned MAX_RESULTS = 4;

   typedef enum logic [6:0] {
      MODE_IDLE  = 7'b0000001,
      MODE_PLAIN = 7'b0000010,
      MODE_ESC   = 7'b0000100,
      MODE_HEX1  = 7'b0001000,
      MODE_HEX2  = 7'b0010000,
      MODE_HEX3  = 7'b0100000,
      MODE_HEX4  = 7'b1000000
   } scan_mode_type;

   typedef enum logic [2:0] {
      ST_BYTE   = 3'd0,
      ST_DONE   = 3'd1,
      ST_CTRL   = 3'd2,
      ST_BADESC = 3'd3,
      ST_BADHEX = 3'd4,
      ST_UNTERM = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
   } result_type;

   // one request's worth of results, count is 1..MAX_RESULTS
   typedef struct packed {
      logic [2:0]                       count;
      result_type [MAX_RESULTS-1:0]     res;
   } run_type;

endpackage

FILE: design/jsu_front.sv
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_byte,
   input  logic              req_starts_string,
   input  logic              req_ends_input,
   input  logic              push_ready,
   output logic              push_valid,
   output jsu_pkg::run_type  push_run
);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   jsu_pkg::scan_mode_type mode_ff, mode_in, mode_eff;
   logic [15:0]            hex_ff, hex_in, hex_eff, code;
   logic                   accept;
   logic [2:0]             n;
   logic                   digit_ok;
   logic [3:0]             digit;
   jsu_pkg::run_type       run;

   always_comb begin
      digit_ok = 1'b1;
      digit    = 4'd0;
      if (req_char_byte >= 8'h30 && req_char_byte <= 8'h39) begin
         digit = req_char_byte[3:0];
      end else if ((req_char_byte >= 8'h61 && req_char_byte <= 8'h66) ||
                   (req_char_byte >= 8'h41 && req_char_byte <= 8'h46)) begin
         digit = req_char_byte[3:0] + 4'd9;
      end else begin
         digit_ok = 1'b0;
      end
   end

   assign accept   = req_valid && req_ready;
   assign mode_eff = req_starts_string ? jsu_pkg::MODE_PLAIN : mode_ff;
   assign hex_eff  = req_starts_string ? 16'd0 : hex_ff;
   assign code     = {hex_eff[11:0], digit};

   always_comb begin
      run     = '0;
      n       = 3'd0;
      mode_in = mode_eff;
      hex_in  = hex_eff;
      unique case (mode_eff)
         jsu_pkg::MODE_PLAIN: begin
            if (req_char_byte == CH_QUOTE) begin
               run.res[0].status = jsu_pkg::ST_DONE;
               n       = 3'd1;
               mode_in = jsu_pkg::MODE_IDLE;
            end else if (req_char_byte == CH_BSL) begin
               mode_in = jsu_pkg::MODE_ESC;
            end else if (req_char_byte < 8'h20) begin
               run.res[0].status = jsu_pkg::ST_CTRL;
               n       = 3'd1;
               mode_in = jsu_pkg::MODE_IDLE;
            end else begin
               run.res[0].out_byte = req_char_byte;
               run.res[0].status   = jsu_pkg::ST_BYTE;
               n = 3'd1;
            end
         end
         jsu_pkg::MODE_ESC: begin
            n       = 3'd1;
            mode_in = jsu_pkg::MODE_PLAIN;
            run.res[0].status = jsu_pkg::ST_BYTE;
            unique case (req_char_byte)
               CH_QUOTE, CH_BSL, CH_SLASH: run.res[0].out_byte = req_char_byte;
               CH_B: run.res[0].out_byte = 8'h08;
               CH_F: run.res[0].out_byte = 8'h0C;
               CH_N: run.res[0].out_byte = 8'h0A;
               CH_R: run.res[0].out_byte = 8'h0D;
               CH_T: run.res[0].out_byte = 8'h09;
               CH_U: begin
                  n       = 3'd0;
                  hex_in  = 16'd0;
                  mode_in = jsu_pkg::MODE_HEX1;
               end
               default: begin
                  run.res[0].status = jsu_pkg::ST_BADESC;
                  mode_in = jsu_pkg::MODE_IDLE;
               end
            endcase
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
         jsu_pkg::MODE_HEX4: begin
            if (!digit_ok) begin
               run.res[0].status = jsu_pkg::ST_BADHEX;
               n       = 3'd1;
               mode_in = jsu_pkg::MODE_IDLE;
            end else begin
               hex_in = code;
               unique case (mode_eff)
                  jsu_pkg::MODE_HEX1: mode_in = jsu_pkg::MODE_HEX2;
                  jsu_pkg::MODE_HEX2: mode_in = jsu_pkg::MODE_HEX3;
                  jsu_pkg::MODE_HEX3: mode_in = jsu_pkg::MODE_HEX4;
                  default: begin
                     mode_in = jsu_pkg::MODE_PLAIN;
                     run.res[0].status = jsu_pkg::ST_BYTE;
                     run.res[1].status = jsu_pkg::ST_BYTE;
                     run.res[2].status = jsu_pkg::ST_BYTE;
                     if (code < 16'h0080) begin
                        run.res[0].out_byte = code[7:0];
                        n = 3'd1;
                     end else if (code < 16'h0800) begin
                        run.res[0].out_byte = 8'hC0 | {3'd0, code[10:6]};
                        run.res[1].out_byte = 8'h80 | {2'd0, code[5:0]};
                        n = 3'd2;
                     end else begin
                        run.res[0].out_byte = 8'hE0 | {4'd0, code[15:12]};
                        run.res[1].out_byte = 8'h80 | {2'd0, code[11:6]};
                        run.res[2].out_byte = 8'h80 | {2'd0, code[5:0]};
                        n = 3'd3;
                     end
                  end
               endcase
            end
         end
         default: begin
            mode_in = jsu_pkg::MODE_IDLE;
         end
      endcase
      if (mode_eff != jsu_pkg::MODE_IDLE && req_ends_input &&
          mode_in != jsu_pkg::MODE_IDLE) begin
         run.res[n[1:0]].out_byte = 8'd0;
         run.res[n[1:0]].status   = jsu_pkg::ST_UNTERM;
         n       = n + 3'd1;
         mode_in = jsu_pkg::MODE_IDLE;
      end
      run.count = n;
   end

   assign req_ready  = push_ready;
   assign push_valid = accept && (n != 3'd0);
   assign push_run   = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_IDLE;
         hex_ff  <= 16'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff  <= hex_in;
      end
   end

endmodule

FILE: design/jsu_queue.sv
module jsu_queue #(
   parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  jsu_pkg::run_type  push_run,
   output logic              pop_valid,
   input  logic              pop_ready,
   output jsu_pkg::run_type  pop_run
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::run_type   slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_run    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

FILE: design/jsu_back.sv
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  jsu_pkg::run_type  pop_run,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic [2:0]        rsp_status,
   output logic              rsp_last_of_run
);

   jsu_pkg::run_type cur_ff;
   logic             valid_ff;
   logic [1:0]       idx_ff;
   logic             at_last, load;

   assign at_last   = ({1'b0, idx_ff} + 3'd1) == cur_ff.count;
   assign load      = !valid_ff || (rsp_ready && at_last);
   assign pop_ready = load;

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = cur_ff.res[idx_ff].out_byte;
   assign rsp_status      = cur_ff.res[idx_ff].status;
   assign rsp_last_of_run = at_last;

   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         cur_ff <= pop_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= pop_valid;
         idx_ff   <= 2'd0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

FILE: design/json_string_unescape.sv
// json_string_unescape: decodes a JSON string body, one character a request.
// Request channel: req_valid/req_ready with req_char_byte, req_starts_string
//   (first character after the opening quote) and req_ends_input (last
//   character available).
// Response channel: rsp_valid/rsp_ready with rsp_out_byte, rsp_status and
//   rsp_last_of_run. A request gives zero to four responses: decoded bytes
//   (up to three for a \u escape), then a done or error status.
// Throughput: one request per cycle, one response per cycle. The responses of
//   a request leave one after another on the response channel; the first
//   response of a request passes through a queue slot and then the back
//   end's run register before it is valid. The front decoder runs in
//   the request cycle and writes one run of results into a queue of
//   QUEUE_DEPTH runs; the back end drains one result per cycle.
// Stall: while rsp_ready is low, responses hold; requests keep being taken
//   until the queue is full, then req_ready drops.
// Reset: mode returns to idle (waiting for a string start), queue and
//   output empty.
module json_string_unescape #(
   parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_starts_string,
   input  logic        req_ends_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_last_of_run
);

   logic             push_valid, push_ready, pop_valid, pop_ready;
   jsu_pkg::run_type push_run, pop_run;

   jsu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .req_starts_string (req_starts_string),
      .req_ends_input    (req_ends_input),
      .push_ready        (push_ready),
      .push_valid        (push_valid),
      .push_run          (push_run)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_run   (push_run),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_run    (pop_run)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_run         (pop_run),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: design/jsu_checker.sv
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_status,
   input logic       rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'(jsu_pkg::ST_UNTERM))
      else $error("status code out of range");

   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 3'(jsu_pkg::ST_BYTE) |->
      rsp_last_of_run && rsp_out_byte == 8'd0)
      else $error("status response not last of run or byte not zero");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_status      (rsp_status),
   .rsp_last_of_run (rsp_last_of_run)
);
